// ----- rtl/core/plsu_pkg.sv -----
package plsu_pkg;

   // fixed field widths of the request and response ports
   localparam int CMD_W       = 3;
   localparam int POS_W       = 5;
   localparam int VAL_W       = 32;
   localparam int CNT_OUT_W   = 5;

   localparam int DEFAULT_DEPTH = 16;
   localparam int DEFAULT_WIDTH = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT  = 3'd0,
      CMD_REMOVE  = 3'd1,
      CMD_READ    = 3'd2,
      CMD_REPLACE = 3'd3,
      CMD_CLEAR   = 3'd4
   } cmd_type;

   // broadcast to every cell of the row
   typedef struct packed {
      logic shift_up;    // cells above the index take their lower neighbor
      logic shift_down;  // cells at or above the index take their upper neighbor
      logic load;        // cell at the index takes the write value
   } cell_ctrl_type;

endpackage

// ----- rtl/core/positional_list_store_unit.sv -----
// Positional list store: an ordered list of up to DEPTH entries addressed by
// 1-based position, held in a row of cells that all shift in one cycle.
// Request channel: start with req_cmd, req_position and req_entry_value; a
// request is taken at a clock edge where start is high and busy is low.
// Commands: insert, remove, read, replace, clear. A bad position, a full list
// on insert or an unknown command gives rsp_ok low and leaves the list as is.
// Response channel: rsp_strobe is high for exactly one cycle, the cycle after
// the request is taken, with rsp_ok, rsp_read_value (nonzero only for a
// successful read), rsp_item_count and rsp_is_empty after the command.
// Latency is one cycle and a new request may be taken every cycle: the whole
// operation is a single update of the cell row plus the response register.
// The receiver cannot stall; the response is simply presented for one cycle.
// Reset empties the list and holds busy high until the cycle after reset
// is released. Entry contents are not cleared; unreached entries never show.
module positional_list_store_unit #(
   parameter int DEPTH = plsu_pkg::DEFAULT_DEPTH,
   parameter int WIDTH = plsu_pkg::DEFAULT_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [plsu_pkg::CMD_W-1:0]     req_cmd,
   input  logic [plsu_pkg::POS_W-1:0]     req_position,
   input  logic [plsu_pkg::VAL_W-1:0]     req_entry_value,
   output logic                           rsp_strobe,
   output logic                           rsp_ok,
   output logic [plsu_pkg::VAL_W-1:0]     rsp_read_value,
   output logic [plsu_pkg::CNT_OUT_W-1:0] rsp_item_count,
   output logic                           rsp_is_empty
);
   import plsu_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   logic               busy_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               rsp_strobe_ff;
   logic               rsp_ok_ff;
   logic               rsp_ok_in;
   logic [VAL_W-1:0]   rsp_read_value_ff;
   logic [VAL_W-1:0]   rsp_read_value_in;

   logic               accept;
   logic [CMP_W-1:0]   pos_ext;
   logic [CMP_W-1:0]   cnt_ext;
   logic               in_range;
   logic               insert_ok;
   logic [IDX_W-1:0]   idx;
   logic [WIDTH-1:0]   wr_value;
   logic [63:0]        wr_wide;
   logic [WIDTH-1:0]   rd_mux;
   logic [63:0]        rd_wide;
   cell_ctrl_type      ctrl;

   logic [WIDTH-1:0]   cell_value [DEPTH];
   logic [WIDTH-1:0]   cell_rd    [DEPTH];

   assign accept   = start && !busy_ff;
   assign pos_ext  = CMP_W'(req_position);
   assign cnt_ext  = CMP_W'(count_ff);
   assign in_range = (pos_ext != '0) && (pos_ext <= cnt_ext);
   assign insert_ok = (pos_ext != '0)
                   && ({1'b0, pos_ext} <= ({1'b0, cnt_ext} + (CMP_W+1)'(1)))
                   && (count_ff < CNT_W'(DEPTH));
   assign idx      = IDX_W'(pos_ext - CMP_W'(1));
   assign wr_wide  = 64'(req_entry_value);
   assign wr_value = wr_wide[WIDTH-1:0];

   // per-command decode: cell controls, next count, response fields
   always_comb begin
      ctrl              = '0;
      count_in          = count_ff;
      rsp_ok_in         = 1'b0;
      rsp_read_value_in = '0;
      if (accept) begin
         unique case (req_cmd)
            CMD_INSERT: begin
               if (insert_ok) begin
                  ctrl.shift_up = 1'b1;
                  ctrl.load     = 1'b1;
                  count_in      = count_ff + CNT_W'(1);
                  rsp_ok_in     = 1'b1;
               end
            end
            CMD_REMOVE: begin
               if (in_range) begin
                  ctrl.shift_down = 1'b1;
                  count_in        = count_ff - CNT_W'(1);
                  rsp_ok_in       = 1'b1;
               end
            end
            CMD_READ: begin
               if (in_range) begin
                  rsp_read_value_in = rd_wide[VAL_W-1:0];
                  rsp_ok_in         = 1'b1;
               end
            end
            CMD_REPLACE: begin
               if (in_range) begin
                  ctrl.load = 1'b1;
                  rsp_ok_in = 1'b1;
               end
            end
            CMD_CLEAR: begin
               count_in  = '0;
               rsp_ok_in = 1'b1;
            end
            default: begin
               rsp_ok_in = 1'b0;
            end
         endcase
      end
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [WIDTH-1:0] prev_value;
      logic [WIDTH-1:0] next_value;
      if (g == 0) begin : g_first
         assign prev_value = cell_value[g];
      end else begin : g_mid_lo
         assign prev_value = cell_value[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign next_value = cell_value[g];
      end else begin : g_mid_hi
         assign next_value = cell_value[g+1];
      end
      plsu_cell #(
         .WIDTH      (WIDTH),
         .IDX_W      (IDX_W),
         .CELL_INDEX (g)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .idx        (idx),
         .wr_value   (wr_value),
         .prev_value (prev_value),
         .next_value (next_value),
         .value      (cell_value[g]),
         .rd_value   (cell_rd[g])
      );
   end

   // only the addressed cell drives a nonzero value
   always_comb begin
      rd_mux = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rd_mux = rd_mux | cell_rd[i];
      end
   end
   assign rd_wide = 64'(rd_mux);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         busy_ff       <= 1'b0;
         count_ff      <= count_in;
         rsp_strobe_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ok_ff         <= rsp_ok_in;
      rsp_read_value_ff <= rsp_read_value_in;
   end

   assign busy           = busy_ff;
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_item_count = CNT_OUT_W'(count_ff);
   assign rsp_is_empty   = (count_ff == '0);

`ifndef SYNTHESIS
   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("response strobe missing after request");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_cmd == CMD_INSERT) && insert_ok)
      |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert did not grow the list");

   a_no_req_no_change: assert property (@(posedge clock) disable iff (reset)
      !accept |=> ($stable(count_ff) && !rsp_strobe))
      else $error("list changed without a request");
`endif

endmodule

// ----- rtl/core/plsu_cell.sv -----
module plsu_cell #(
   parameter int WIDTH      = 32,
   parameter int IDX_W      = 4,
   parameter int CELL_INDEX = 0
) (
   input  logic                    clock,
   input  plsu_pkg::cell_ctrl_type ctrl,
   input  logic [IDX_W-1:0]        idx,
   input  logic [WIDTH-1:0]        wr_value,
   input  logic [WIDTH-1:0]        prev_value,
   input  logic [WIDTH-1:0]        next_value,
   output logic [WIDTH-1:0]        value,
   output logic [WIDTH-1:0]        rd_value
);
   import plsu_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

   logic [WIDTH-1:0] value_ff;
   logic [WIDTH-1:0] value_in;
   logic             at_idx;
   logic             above_idx;

   assign at_idx    = (idx == MY_IDX);
   assign above_idx = (MY_IDX > idx);

   always_comb begin
      priority if (ctrl.load && at_idx) begin
         value_in = wr_value;
      end else if (ctrl.shift_up && above_idx) begin
         value_in = prev_value;
      end else if (ctrl.shift_down && (above_idx || at_idx)) begin
         value_in = next_value;
      end else begin
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value    = value_ff;
   assign rd_value = at_idx ? value_ff : '0;

endmodule
